### sv/combination_enumerator_assert.svh
// Assertion macros shared by the combination enumerator RTL.
`ifndef COMBINATION_ENUMERATOR_ASSERT_SVH
`define COMBINATION_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("combination_enumerator: assertion failed");

// Next-cycle implication, disabled during reset.
`define CE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("combination_enumerator: assertion failed");

`endif

### sv/comb_enum_pkg.sv
// Shared types and constants of the combination enumerator.
package comb_enum_pkg;

  localparam int NW    = 7;   // n_total register width
  localparam int KFW   = 5;   // k_chosen register width
  localparam int IDXW  = 6;   // index_value result width
  localparam int CMP_W = 9;   // width for n, k and bound compares

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  localparam logic REG_N_TOTAL  = 1'b0;
  localparam logic REG_K_CHOSEN = 1'b1;

  typedef struct packed {
    logic           wr;
    logic [NW-1:0]  n_total;
    logic [KFW-1:0] k_chosen;
  } cfg_t;

endpackage

### sv/combination_enumerator.sv
// Top level of the lexicographic k-combination enumerator.
//
// Each request (restart = 1 starts over at 0..k-1) returns the current k-subset as k
// result transfers, ascending, then steps to the next subset; with k = 0, k > n,
// k > MAX_K or n > MAX_N, or after the last subset, a request returns one status = 1
// transfer. The subset lives in a MAX_K-entry memory with one write and one registered
// read port. A request loads the first subset into memory after reset, restart or a
// register write, streams the subset out through the read port, then rewrites the tail
// from the raised position p with memory writes. The block takes no request until
// this sequence is done; a finished result may wait in the output register meanwhile.
module combination_enumerator #(
  parameter int MAX_N = 64,
  parameter int MAX_K = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            restart,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [comb_enum_pkg::IDXW-1:0]  index_value,
  output logic                            last_in_subset,
  output logic                            final_subset,
  output logic                            status
);
  import comb_enum_pkg::*;

  localparam int IW = (MAX_N > 2) ? $clog2(MAX_N) : 1;
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KW = $clog2(MAX_K + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_EMIT = 5'b00100,
    S_NONE = 5'b01000,
    S_ADV  = 5'b10000
  } state_t;

  cfg_t           cfg;
  state_t         state;
  logic           loaded;
  logic           exhausted;
  logic [KW-1:0]  k_len;
  logic           cfg_ok;
  logic [CMP_W-1:0] n_minus_k;
  logic           req_acc;

  logic [IW-1:0]  mem [MAX_K];
  logic [IW-1:0]  rdata;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  waddr;
  logic [IW-1:0]  wdata;

  logic [KW-1:0]  rcnt;
  logic [KW-1:0]  ecnt;
  logic [KW-1:0]  wcnt;
  logic [IW-1:0]  wval;
  logic           rv;
  logic           found;
  logic [KW-1:0]  fp;
  logic [IW-1:0]  fv;
  logic           final_reg;

  logic           b_ready;
  logic           a_move;
  logic           issue;
  logic           fin_now;
  logic           below_max;
  logic           emit_done;

  comb_enum_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign k_len     = KW'(cfg.k_chosen);
  assign cfg_ok    = (cfg.k_chosen != '0)
                  && (CMP_W'(cfg.k_chosen) <= CMP_W'(cfg.n_total))
                  && (CMP_W'(cfg.k_chosen) <= CMP_W'(MAX_K))
                  && (CMP_W'(cfg.n_total) <= CMP_W'(MAX_N));
  assign n_minus_k = CMP_W'(cfg.n_total) - CMP_W'(cfg.k_chosen);

  // Hold off a request in the cycle a register write lands.
  assign req_stall = (state != S_IDLE) || cfg.wr;
  assign req_acc   = req_valid && !req_stall;

  // Read stage feeds the output register; both advance like a two-entry pipe.
  assign b_ready   = !res_valid || !res_stall;
  assign a_move    = rv && b_ready;
  assign issue     = (state == S_EMIT) && (rcnt != k_len) && (!rv || a_move);
  assign emit_done = (state == S_EMIT) && (rcnt == k_len) && !rv;
  assign fin_now   = (CMP_W'(rdata) == n_minus_k);
  assign below_max = (CMP_W'(rdata) < (n_minus_k + CMP_W'(ecnt)));

  assign mem_we = (state == S_LOAD) || (state == S_ADV);
  assign mem_re = issue;
  assign waddr  = wcnt[AW-1:0];
  assign wdata  = (state == S_LOAD) ? IW'(wcnt) : wval;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[rcnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= 1'b0;
      exhausted <= 1'b0;
      rv        <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.wr) begin
            loaded    <= 1'b0;
            exhausted <= 1'b0;
          end else if (req_acc) begin
            if (!cfg_ok) begin
              state <= S_NONE;
              if (restart) begin
                loaded    <= 1'b0;
                exhausted <= 1'b0;
              end
            end else if (!loaded || restart) begin
              state     <= S_LOAD;
              wcnt      <= '0;
              loaded    <= 1'b1;
              exhausted <= 1'b0;
            end else if (exhausted) begin
              state <= S_NONE;
            end else begin
              state <= S_EMIT;
              rcnt  <= '0;
              found <= 1'b0;
            end
          end
        end
        S_LOAD: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == k_len - 1'b1) begin
            state <= S_EMIT;
            rcnt  <= '0;
            found <= 1'b0;
          end
        end
        S_EMIT: begin
          if (issue) begin
            rcnt <= rcnt + 1'b1;
            ecnt <= rcnt;
            rv   <= 1'b1;
          end else if (a_move) begin
            rv <= 1'b0;
          end
          // Track the rightmost element still below its maximum.
          if (a_move) begin
            if (below_max) begin
              found <= 1'b1;
              fp    <= ecnt;
              fv    <= rdata;
            end
            if (ecnt == '0) begin
              final_reg <= fin_now;
            end
          end
          if (emit_done) begin
            if (found) begin
              state <= S_ADV;
              wcnt  <= fp;
              wval  <= fv + 1'b1;
            end else begin
              state     <= S_IDLE;
              exhausted <= 1'b1;
            end
          end
        end
        S_NONE: begin
          if (b_ready) begin
            state <= S_IDLE;
          end
        end
        S_ADV: begin
          wcnt <= wcnt + 1'b1;
          wval <= wval + 1'b1;
          if (wcnt == k_len - 1'b1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_NONE) && b_ready) begin
      res_valid <= 1'b1;
    end else if (a_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_NONE) && b_ready) begin
      index_value    <= '0;
      last_in_subset <= 1'b0;
      final_subset   <= 1'b0;
      status         <= STATUS_NONE;
    end else if (a_move) begin
      index_value    <= IDXW'(rdata);
      last_in_subset <= (ecnt == k_len - 1'b1);
      final_subset   <= (ecnt == '0) ? fin_now : final_reg;
      status         <= STATUS_OK;
    end
  end

`include "combination_enumerator_assert.svh"

  `CE_ASSERT_IMP(a_rdata_in_emit, clk, rst, rv, state == S_EMIT)
  `CE_ASSERT_IMP(a_read_in_range, clk, rst, issue, rcnt < k_len)
  `CE_ASSERT_IMP(a_write_in_range, clk, rst, mem_we, wcnt < k_len)
  `CE_ASSERT_NXT(a_exhaust_on_end, clk, rst, emit_done && !found, (state == S_IDLE) && exhausted)

endmodule

### sv/comb_enum_cfg.sv
// Configuration register file behind the APB-style port.
module comb_enum_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output comb_enum_pkg::cfg_t cfg
);
  import comb_enum_pkg::*;

  logic [NW-1:0]  n_total;
  logic [KFW-1:0] k_chosen;
  logic           wr_en;
  logic           reg_sel;

  // Word select only; the low address bits do not decode.
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_total  <= '0;
      k_chosen <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_N_TOTAL:  n_total  <= pwdata[NW-1:0];
        REG_K_CHOSEN: k_chosen <= pwdata[KFW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_N_TOTAL:  prdata = 32'(n_total);
      REG_K_CHOSEN: prdata = 32'(k_chosen);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{wr: wr_en, n_total: n_total, k_chosen: k_chosen};

endmodule

### tb/sv/tb_combination_enumerator.sv
// Self-checking testbench for the lexicographic k-combination enumerator.
module tb_combination_enumerator;
  import comb_enum_pkg::*;

  localparam int MAX_N        = 64;
  localparam int MAX_K        = 16;
  localparam int DIRECTED     = 72;
  localparam int RANDOM_ITEMS = 38;
  localparam int QUIET_TAIL   = 25;
  localparam int SETTLE       = 2 * MAX_K + 8;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT        = 400000;

  typedef struct packed {
    logic [IDXW-1:0] index;
    logic            last_idx;
    logic            last_set;
    logic            stat;
  } subset_result_t;

  class subset_tracker;
    int             n_sel;
    int             k_sel;
    int             cur_subset[MAX_K];
    bit             loaded;
    bit             exhausted;
    subset_result_t due[$];
    int             errors;
    int             checked;
    int             none_seen;

    function new();
      n_sel = 0;
      k_sel = 0;
      loaded = 0;
      exhausted = 0;
      errors = 0;
      checked = 0;
      none_seen = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void config_write(logic idx, logic [31:0] data);
      if (idx == REG_N_TOTAL) n_sel = int'(data[NW-1:0]);
      else k_sel = int'(data[KFW-1:0]);
      loaded = 0;
      exhausted = 0;
    endfunction

    function void push_none();
      subset_result_t r;
      r.index = '0;
      r.last_idx = 1'b0;
      r.last_set = 1'b0;
      r.stat = STATUS_NONE;
      due.insert(due.size(), r);
    endfunction

    // Expected transfers for one accepted request, then step to the next subset.
    function void note_request(bit rs);
      subset_result_t r;
      bit             fin;
      int             pos;
      if (rs) begin
        loaded = 0;
        exhausted = 0;
      end
      if (k_sel == 0 || k_sel > n_sel || k_sel > MAX_K || n_sel > MAX_N) begin
        push_none();
        return;
      end
      if (!loaded) begin
        for (int i = 0; i < k_sel; i++) cur_subset[i] = i;
        loaded = 1;
        exhausted = 0;
      end
      if (exhausted) begin
        push_none();
        return;
      end
      fin = (cur_subset[0] == n_sel - k_sel);
      for (int i = 0; i < k_sel; i++) begin
        r.index = cur_subset[i][IDXW-1:0];
        r.last_idx = (i + 1 == k_sel);
        r.last_set = fin;
        r.stat = STATUS_OK;
        due.insert(due.size(), r);
      end
      // raise the rightmost entry still below its ceiling, refill the tail
      pos = -1;
      for (int i = k_sel; i > 0 && pos < 0; i--)
        if (cur_subset[i-1] < n_sel - k_sel + i - 1) pos = i - 1;
      if (pos < 0) begin
        exhausted = 1;
      end else begin
        cur_subset[pos]++;
        for (int i = pos + 1; i < k_sel; i++) cur_subset[i] = cur_subset[i-1] + 1;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [IDXW-1:0] idx, logic last_idx, logic last_set,
                               logic stat);
      subset_result_t want;
      if (due.size() == 0) begin
        $error("unexpected transfer: index_value=%0d status=%0d", idx, stat);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (want.stat == STATUS_NONE) none_seen++;
      compare_field("index_value", 8'(want.index), 8'(idx));
      compare_field("last_in_subset", 8'(want.last_idx), 8'(last_idx));
      compare_field("final_subset", 8'(want.last_set), 8'(last_set));
      compare_field("status", 8'(want.stat), 8'(stat));
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;
  logic            req_valid;
  logic            req_stall;
  logic            restart;
  logic            res_valid;
  logic            res_stall;
  logic [IDXW-1:0] index_value;
  logic            last_in_subset;
  logic            final_subset;
  logic            status;

  subset_tracker tracker;
  int            sent;
  int            cfg_writes;
  int            cycles;
  bit            idling;
  bit            long_hold;

  combination_enumerator #(.MAX_N(MAX_N), .MAX_K(MAX_K)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .restart(restart),
    .res_valid(res_valid), .res_stall(res_stall),
    .index_value(index_value), .last_in_subset(last_in_subset),
    .final_subset(final_subset), .status(status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d transfers outstanding", cycles,
               tracker.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      tracker.check_result(index_value, last_in_subset, final_subset, status);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        res_stall = 1'b0;
        long_hold = 1'b0;
      end else if (!rst && idling && $urandom_range(0, 5) == 0) begin
        res_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        res_stall = 1'b0;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  task automatic send_request(input bit rs);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      restart = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_valid = 1'b1;
    restart = rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(rs);
    sent++;
  endtask

  // Drop valid, wait for every expected transfer, then let the advance finish.
  task automatic settle();
    @(negedge clk);
    req_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.config_write(idx, data);
    cfg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Fill the unused upper bits of the write data now and then.
  function automatic logic [31:0] reg_word(int v, int w);
    if ($urandom_range(0, 1)) return ($urandom << w) | 32'(v);
    return 32'(v);
  endfunction

  task automatic apply_config(input int n, input int k);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_N_TOTAL, reg_word(n, NW));
      write_reg(REG_K_CHOSEN, reg_word(k, KFW));
    end else begin
      write_reg(REG_K_CHOSEN, reg_word(k, KFW));
      write_reg(REG_N_TOTAL, reg_word(n, NW));
    end
  endtask

  function automatic longint subsets_of(int n, int k);
    longint r;
    r = 1;
    for (int i = 0; i < k; i++) r = r * (n - i) / (i + 1);
    return r;
  endfunction

  initial begin
    int     n;
    int     k;
    int     count;
    longint total;
    tracker = new();
    sent = 0;
    cfg_writes = 0;
    cycles = 0;
    idling = 1'b1;
    long_hold = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    restart = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration has k = 0
    send_request(1'b0);
    // k equal to n: one subset, then exhausted, then restart
    apply_config(4, 4);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    // k = 1 walks every single index through exhaustion
    apply_config(3, 1);
    repeat (4) send_request(1'b0);
    // restart in mid-sequence
    apply_config(5, 2);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    // empty and oversized subsets
    apply_config(10, 0);
    send_request(1'b0);
    apply_config(3, 4);
    send_request(1'b0);
    apply_config(64, 17);
    send_request(1'b0);
    apply_config(127, 31);
    send_request(1'b1);
    apply_config(65, 1);
    send_request(1'b0);
    // largest valid setting
    apply_config(64, 16);
    send_request(1'b1);
    send_request(1'b0);
    // rewriting an unchanged register still starts over
    apply_config(3, 2);
    send_request(1'b0);
    send_request(1'b0);
    settle();
    write_reg(REG_K_CHOSEN, 32'd2);
    send_request(1'b0);

    // deep walk at full size under one long output hold-off; it reaches the top index
    apply_config(MAX_N, MAX_K);
    long_hold = 1'b1;
    repeat (50) send_request(1'b0);

    while (sent < DIRECTED + RANDOM_ITEMS) begin
      if (sent >= DIRECTED + RANDOM_ITEMS - QUIET_TAIL) idling = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(0, 127);
          k = $urandom_range(MAX_K + 1, 31);
        end
        1: begin
          n = $urandom_range(MAX_N + 1, 127);
          k = $urandom_range(0, MAX_K);
        end
        2: begin
          n = $urandom_range(0, 15);
          k = $urandom_range(n + 1, MAX_K);
        end
        3: begin
          n = $urandom_range(0, 127);
          k = 0;
        end
        4: begin
          n = $urandom_range(9, MAX_N);
          k = $urandom_range(1, MAX_K);
        end
        default: begin
          n = $urandom_range(1, 7);
          k = $urandom_range(1, n);
        end
      endcase
      if (k == 0 || k > n || k > MAX_K || n > MAX_N) begin
        count = $urandom_range(1, 3);
      end else begin
        total = subsets_of(n, k);
        count = (total <= 20) ? int'(total) + $urandom_range(1, 3) : $urandom_range(5, 12);
      end
      apply_config(n, k);
      repeat (count) send_request($urandom_range(0, 15) == 0);
    end

    settle();
    $display("%0d requests over %0d register writes; %0d transfers checked, %0d of them none",
             sent, cfg_writes, tracker.checked, tracker.none_seen);
    $display("settings ranged from empty and oversized to n=%0d k=%0d walks", MAX_N, MAX_K);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
